// ----- rtl/write_watch_range_table_assert.svh -----
`ifndef WRITE_WATCH_RANGE_TABLE_ASSERT_SVH
`define WRITE_WATCH_RANGE_TABLE_ASSERT_SVH

// same-cycle implication, sampled on clk, quiet in reset
`define WWRT_ASSERT_NOW(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// next-cycle implication, sampled on clk, quiet in reset
`define WWRT_ASSERT_NEXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

// ----- rtl/wwrt_pkg.sv -----
package wwrt_pkg;

	localparam int KEY_W    = 64;
	localparam int ADDR_W   = 32;
	localparam int LEN_W    = 32;
	localparam int STATUS_W = 2;

	localparam logic REQ_PROTECT = 1'b0;
	localparam logic REQ_NOTICE  = 1'b1;

	localparam logic [STATUS_W-1:0] ST_OK       = 2'd0;
	localparam logic [STATUS_W-1:0] ST_FULL     = 2'd1;
	localparam logic [STATUS_W-1:0] ST_OVERFLOW = 2'd2;

endpackage

// ----- rtl/wwrt_slot_mem.sv -----
module wwrt_slot_mem #(
	parameter int DEPTH  = 16,
	parameter int IDX_W  = 4,
	parameter int DATA_W = 105
) (
	input  logic              clk,
	input  logic              wr_en,
	input  logic [IDX_W-1:0]  wr_idx,
	input  logic [DATA_W-1:0] wr_data,
	input  logic              rd_en,
	input  logic [IDX_W-1:0]  rd_idx,
	output logic [DATA_W-1:0] rd_data
);

	logic [DATA_W-1:0] mem_q [DEPTH];
	logic [DATA_W-1:0] rd_data_q;

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem_q[wr_idx] <= wr_data;
		end
		if (rd_en) begin
			rd_data_q <= mem_q[rd_idx];
		end
	end

	assign rd_data = rd_data_q;

endmodule

// ----- rtl/wwrt_cmp.sv -----
module wwrt_cmp #(
	parameter int SP_W = 20
) (
	input  logic            valid,
	input  logic [SP_W-1:0] addr_page,
	input  logic [SP_W-1:0] start_page,
	input  logic [SP_W:0]   page_count,
	output logic            hit
);

	logic [SP_W:0] end_page;

	// half-open page range, end kept one bit wider so it never wraps
	assign end_page = {1'b0, start_page} + page_count;
	assign hit = valid && (addr_page >= start_page) && ({1'b0, addr_page} < end_page);

endmodule

// ----- rtl/write_watch_range_table.sv -----
// channel   signals                                      transaction
// request   start, busy, req_type, key, address, length  start high while busy low
// result    done, resp_type, released_key, handled,      done high, one cycle each
//           status, last
//
// a protect ends at the length check when that check answers it; else it goes on to walk the
// slots, one per cycle, up to the first free one. a write notice reads one slot per cycle from
// the slot memory through the shared range compare, then gives the final result in a last step.
// reset clears only the valid bits, so no clearing pass.
// results appear on done with no stall; busy stays high until the last result is out.
module write_watch_range_table #(
	parameter int TABLE_DEPTH = 16,
	parameter int PAGE_BITS   = 12
) (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           start,
	output logic                           busy,
	input  logic                           req_type,
	input  logic [wwrt_pkg::KEY_W-1:0]     key,
	input  logic [wwrt_pkg::ADDR_W-1:0]    address,
	input  logic [wwrt_pkg::LEN_W-1:0]     length,
	output logic                           done,
	output logic                           resp_type,
	output logic [wwrt_pkg::KEY_W-1:0]     released_key,
	output logic                           handled,
	output logic [wwrt_pkg::STATUS_W-1:0]  status,
	output logic                           last
);

	import wwrt_pkg::*;

	localparam int IDX_W = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
	localparam int SP_W  = ADDR_W - PAGE_BITS;
	localparam int CNT_W = SP_W + 1;
	localparam logic [IDX_W-1:0] IDX_LAST  = IDX_W'(TABLE_DEPTH - 1);
	localparam logic [LEN_W:0]   PAGE_MASK = (LEN_W + 1)'((1 << PAGE_BITS) - 1);

	localparam logic [2:0] S_IDLE  = 3'd0;
	localparam logic [2:0] S_PCHK  = 3'd1;
	localparam logic [2:0] S_PSCAN = 3'd2;
	localparam logic [2:0] S_NOTE  = 3'd3;
	localparam logic [2:0] S_FIN   = 3'd4;

	typedef struct packed {
		logic [KEY_W-1:0] key;
		logic [SP_W-1:0]  start_page;
		logic [CNT_W-1:0] page_count;
	} entry_t;

	localparam int ENTRY_W = $bits(entry_t);

	logic [2:0]             state_q;
	logic [IDX_W-1:0]       idx_q;
	logic                   iss_q;
	logic                   rd_v_s1;
	logic [IDX_W-1:0]       idx_s1;
	logic [TABLE_DEPTH-1:0] valid_q;
	logic                   pend_q;
	logic [KEY_W-1:0]       pend_key_q;
	logic [KEY_W-1:0]       key_q;
	logic [SP_W-1:0]        apage_q;
	logic [CNT_W-1:0]       pages_q;

	logic                   done_q;
	logic                   resp_type_q;
	logic [KEY_W-1:0]       rkey_q;
	logic                   handled_q;
	logic [STATUS_W-1:0]    status_q;
	logic                   last_q;

	logic [LEN_W:0]         len_sum;
	logic [CNT_W-1:0]       pages_d;
	logic                   accept;
	logic                   wr_en;
	logic                   rd_en;
	entry_t                 wr_ent;
	logic [ENTRY_W-1:0]     rd_data;
	entry_t                 rd_ent;
	logic                   hit_raw;
	logic                   hit;

	logic                   emit;
	logic                   e_type;
	logic [KEY_W-1:0]       e_key;
	logic                   e_handled;
	logic [STATUS_W-1:0]    e_status;
	logic                   e_last;

	assign accept  = start && (state_q == S_IDLE);
	assign busy    = (state_q != S_IDLE);
	assign len_sum = {1'b0, length} + PAGE_MASK;
	assign pages_d = len_sum[LEN_W:PAGE_BITS];

	assign wr_en  = (state_q == S_PSCAN) && !valid_q[idx_q];
	assign rd_en  = (state_q == S_NOTE) && iss_q;
	assign wr_ent = '{key: key_q, start_page: apage_q, page_count: pages_q};
	assign rd_ent = rd_data;

	wwrt_slot_mem #(
		.DEPTH  (TABLE_DEPTH),
		.IDX_W  (IDX_W),
		.DATA_W (ENTRY_W)
	) u_mem (
		.clk     (clk),
		.wr_en   (wr_en),
		.wr_idx  (idx_q),
		.wr_data (wr_ent),
		.rd_en   (rd_en),
		.rd_idx  (idx_q),
		.rd_data (rd_data)
	);

	wwrt_cmp #(
		.SP_W (SP_W)
	) u_cmp (
		.valid      (rd_v_s1 && valid_q[idx_s1]),
		.addr_page  (apage_q),
		.start_page (rd_ent.start_page),
		.page_count (rd_ent.page_count),
		.hit        (hit_raw)
	);

	assign hit = hit_raw && (state_q == S_NOTE);

	always_comb begin
		emit      = 1'b0;
		e_type    = REQ_PROTECT;
		e_key     = '0;
		e_handled = 1'b0;
		e_status  = ST_OK;
		e_last    = 1'b1;
		unique case (state_q)
			S_PCHK: begin
				emit = pages_q[CNT_W-1] || (pages_q == '0);
				if (pages_q[CNT_W-1]) begin
					e_status = ST_OVERFLOW;
				end
			end
			S_PSCAN: begin
				if (!valid_q[idx_q]) begin
					emit = 1'b1;
				end else if (idx_q == IDX_LAST) begin
					emit     = 1'b1;
					e_status = ST_FULL;
				end
			end
			S_NOTE: begin
				e_type = REQ_NOTICE;
				// a new hit pushes out the one held back
				if (hit && pend_q) begin
					emit      = 1'b1;
					e_key     = pend_key_q;
					e_handled = 1'b1;
					e_last    = 1'b0;
				end
			end
			S_FIN: begin
				emit      = 1'b1;
				e_type    = REQ_NOTICE;
				e_key     = pend_q ? pend_key_q : '0;
				e_handled = pend_q;
			end
			default: begin
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			idx_q   <= '0;
			iss_q   <= 1'b0;
			rd_v_s1 <= 1'b0;
			valid_q <= '0;
			pend_q  <= 1'b0;
			done_q  <= 1'b0;
		end else begin
			done_q  <= emit;
			rd_v_s1 <= rd_en;
			unique case (state_q)
				S_IDLE: begin
					if (start) begin
						state_q <= (req_type == REQ_NOTICE) ? S_NOTE : S_PCHK;
						idx_q   <= '0;
						iss_q   <= 1'b1;
						pend_q  <= 1'b0;
					end
				end
				S_PCHK: begin
					state_q <= emit ? S_IDLE : S_PSCAN;
				end
				S_PSCAN: begin
					if (!valid_q[idx_q]) begin
						valid_q[idx_q] <= 1'b1;
						state_q        <= S_IDLE;
					end else if (idx_q == IDX_LAST) begin
						state_q <= S_IDLE;
					end else begin
						idx_q <= idx_q + IDX_W'(1);
					end
				end
				S_NOTE: begin
					if (iss_q) begin
						if (idx_q == IDX_LAST) begin
							iss_q <= 1'b0;
						end else begin
							idx_q <= idx_q + IDX_W'(1);
						end
					end
					if (hit) begin
						valid_q[idx_s1] <= 1'b0;
						pend_q          <= 1'b1;
					end
					if (rd_v_s1 && (idx_s1 == IDX_LAST)) begin
						state_q <= S_FIN;
					end
				end
				S_FIN: begin
					state_q <= S_IDLE;
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			key_q   <= key;
			apage_q <= address[ADDR_W-1:PAGE_BITS];
			pages_q <= pages_d;
		end
		idx_s1 <= idx_q;
		if (hit) begin
			pend_key_q <= rd_ent.key;
		end
		if (emit) begin
			resp_type_q <= e_type;
			rkey_q      <= e_key;
			handled_q   <= e_handled;
			status_q    <= e_status;
			last_q      <= e_last;
		end
	end

	assign done         = done_q;
	assign resp_type    = resp_type_q;
	assign released_key = rkey_q;
	assign handled      = handled_q;
	assign status       = status_q;
	assign last         = last_q;

endmodule

// ----- rtl/wwrt_check.sv -----
`include "write_watch_range_table_assert.svh"

module wwrt_check (
	input logic                          clk,
	input logic                          arst_n,
	input logic                          start,
	input logic                          busy,
	input logic                          done,
	input logic                          resp_type,
	input logic [wwrt_pkg::KEY_W-1:0]    released_key,
	input logic                          handled,
	input logic [wwrt_pkg::STATUS_W-1:0] status,
	input logic                          last
);

	import wwrt_pkg::*;

	`WWRT_ASSERT_NOW(a_hit_is_notice, done && handled, (resp_type == REQ_NOTICE) && (status == ST_OK), "hit result not an ok write notice")
	`WWRT_ASSERT_NOW(a_protect_single, done && (resp_type == REQ_PROTECT), last && !handled, "protect result not a single final transaction")
	`WWRT_ASSERT_NOW(a_miss_is_last, done && !handled, last && (released_key == '0), "non-hit result not final or carries a key")
	`WWRT_ASSERT_NEXT(a_accept_busy, start && !busy, busy && !done, "accepted request did not raise busy")
	`WWRT_ASSERT_NEXT(a_quiet_after_last, done && last, !done, "result follows the final one")

endmodule

bind write_watch_range_table wwrt_check u_check (
	.clk          (clk),
	.arst_n       (arst_n),
	.start        (start),
	.busy         (busy),
	.done         (done),
	.resp_type    (resp_type),
	.released_key (released_key),
	.handled      (handled),
	.status       (status),
	.last         (last)
);

// ----- test/write_watch_range_table_checker.sv -----
`timescale 1ns / 100ps

module write_watch_range_table_checker #(
	parameter int TABLE_DEPTH = 16,
	parameter int PAGE_BITS   = 12
) (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           start,
	input  logic                           busy,
	input  logic                           req_type,
	input  logic [wwrt_pkg::KEY_W-1:0]     key,
	input  logic [wwrt_pkg::ADDR_W-1:0]    address,
	input  logic [wwrt_pkg::LEN_W-1:0]     length,
	input  logic                           done,
	input  logic                           resp_type,
	input  logic [wwrt_pkg::KEY_W-1:0]     released_key,
	input  logic                           handled,
	input  logic [wwrt_pkg::STATUS_W-1:0]  status,
	input  logic                           last,
	output int                             failures,
	output int                             pending
);

	import wwrt_pkg::*;

	localparam int PAGE_NUM_W = ADDR_W - PAGE_BITS;
	localparam int COUNT_W    = PAGE_NUM_W + 1;

	typedef struct {
		logic                resp_type;
		logic [KEY_W-1:0]    released_key;
		logic                handled;
		logic [STATUS_W-1:0] status;
		logic                last;
	} watch_report_t;

	logic                  range_valid [TABLE_DEPTH];
	logic [KEY_W-1:0]      range_key   [TABLE_DEPTH];
	logic [PAGE_NUM_W-1:0] range_page  [TABLE_DEPTH];
	logic [COUNT_W-1:0]    range_count [TABLE_DEPTH];

	watch_report_t due_reports[$];
	int mismatches = 0;

	function automatic watch_report_t make_report(input logic rt, input logic [KEY_W-1:0] k,
			input logic h, input logic [STATUS_W-1:0] st, input logic l);
		watch_report_t r;
		r.resp_type = rt;
		r.released_key = k;
		r.handled = h;
		r.status = st;
		r.last = l;
		return r;
	endfunction

	function automatic void queue_report(input watch_report_t r);
		due_reports.insert(due_reports.size(), r);
	endfunction

	function automatic void record_protect(input logic [KEY_W-1:0] k,
			input logic [ADDR_W-1:0] a, input logic [LEN_W-1:0] len);
		longint unsigned pages;
		longint unsigned page_mask;
		int slot;
		page_mask = (64'd1 << PAGE_BITS) - 1;
		pages = (64'(len) + page_mask) >> PAGE_BITS;
		slot = -1;
		if ((pages << PAGE_BITS) > 64'hFFFF_FFFF) begin
			queue_report(make_report(REQ_PROTECT, '0, 1'b0, ST_OVERFLOW, 1'b1));
		end else if (pages == 0) begin
			queue_report(make_report(REQ_PROTECT, '0, 1'b0, ST_OK, 1'b1));
		end else begin
			for (int i = 0; i < TABLE_DEPTH; i++) begin
				if (!range_valid[i] && slot < 0)
					slot = i;
			end
			if (slot < 0) begin
				queue_report(make_report(REQ_PROTECT, '0, 1'b0, ST_FULL, 1'b1));
			end else begin
				range_valid[slot] = 1'b1;
				range_key[slot] = k;
				range_page[slot] = a[ADDR_W-1:PAGE_BITS];
				range_count[slot] = COUNT_W'(pages);
				queue_report(make_report(REQ_PROTECT, '0, 1'b0, ST_OK, 1'b1));
			end
		end
	endfunction

	// half-open compare, done in 64 bits so a range past the top never wraps
	function automatic void record_write(input logic [ADDR_W-1:0] a);
		longint unsigned lo;
		longint unsigned hi;
		longint unsigned span;
		longint unsigned at;
		watch_report_t tail;
		int hits;
		hits = 0;
		at = 64'(a);
		for (int i = 0; i < TABLE_DEPTH; i++) begin
			if (range_valid[i]) begin
				lo = 64'(range_page[i]) << PAGE_BITS;
				span = 64'(range_count[i]) << PAGE_BITS;
				hi = lo + span;
				if (at >= lo && at < hi) begin
					range_valid[i] = 1'b0;
					queue_report(make_report(REQ_NOTICE, range_key[i], 1'b1, ST_OK, 1'b0));
					hits++;
				end
			end
		end
		if (hits == 0) begin
			queue_report(make_report(REQ_NOTICE, '0, 1'b0, ST_OK, 1'b1));
		end else begin
			tail = due_reports.pop_back();
			tail.last = 1'b1;
			queue_report(tail);
		end
	endfunction

	task automatic check_field(input string field, input logic [KEY_W-1:0] want,
			input logic [KEY_W-1:0] got);
		if (got !== want) begin
			$error("%s: expected %0h, actual %0h", field, want, got);
			mismatches++;
		end
	endtask

	always @(posedge clk) begin
		watch_report_t want;
		if (!arst_n) begin
			foreach (range_valid[i])
				range_valid[i] = 1'b0;
			due_reports.delete();
		end else begin
			if (done) begin
				if (due_reports.size() == 0) begin
					$error("unexpected result: resp_type %0h released_key %0h status %0h",
						resp_type, released_key, status);
					mismatches++;
				end else begin
					want = due_reports.pop_front();
					check_field("resp_type", KEY_W'(want.resp_type), KEY_W'(resp_type));
					check_field("released_key", want.released_key, released_key);
					check_field("handled", KEY_W'(want.handled), KEY_W'(handled));
					check_field("status", KEY_W'(want.status), KEY_W'(status));
					check_field("last", KEY_W'(want.last), KEY_W'(last));
				end
			end
			if (start && !busy) begin
				if (req_type == REQ_PROTECT)
					record_protect(key, address, length);
				else
					record_write(address);
			end
		end
		failures <= mismatches;
		pending <= due_reports.size();
	end

endmodule

// ----- test/write_watch_range_table_tb.sv -----
`timescale 1ns / 100ps

module write_watch_range_table_tb;
	import wwrt_pkg::*;

	localparam int TABLE_DEPTH = 16;
	localparam int PAGE_BITS   = 12;
	localparam int PAGE_SIZE   = 1 << PAGE_BITS;
	localparam int QUIET_LIMIT = 2000;
	localparam int PHASE_ITEMS = 18;

	logic                 clk;
	logic                 arst_n;
	logic                 start;
	logic                 busy;
	logic                 req_type;
	logic [KEY_W-1:0]     key;
	logic [ADDR_W-1:0]    address;
	logic [LEN_W-1:0]     length;
	logic                 done;
	logic                 resp_type;
	logic [KEY_W-1:0]     released_key;
	logic                 handled;
	logic [STATUS_W-1:0]  status;
	logic                 last;

	int failures;
	int pending;
	int quiet_cycles = 0;
	int idle_pct = 0;
	int idle_plan[4] = '{0, 54, 0, 33};
	logic [ADDR_W-1:0] hot_addrs[$];

	write_watch_range_table #(
		.TABLE_DEPTH(TABLE_DEPTH),
		.PAGE_BITS(PAGE_BITS)
	) u_dut (
		.clk(clk),
		.arst_n(arst_n),
		.start(start),
		.busy(busy),
		.req_type(req_type),
		.key(key),
		.address(address),
		.length(length),
		.done(done),
		.resp_type(resp_type),
		.released_key(released_key),
		.handled(handled),
		.status(status),
		.last(last)
	);

	write_watch_range_table_checker #(
		.TABLE_DEPTH(TABLE_DEPTH),
		.PAGE_BITS(PAGE_BITS)
	) u_checker (
		.clk(clk),
		.arst_n(arst_n),
		.start(start),
		.busy(busy),
		.req_type(req_type),
		.key(key),
		.address(address),
		.length(length),
		.done(done),
		.resp_type(resp_type),
		.released_key(released_key),
		.handled(handled),
		.status(status),
		.last(last),
		.failures(failures),
		.pending(pending)
	);

	initial begin
		clk = 1'b0;
		forever #10 clk = ~clk;
	end

	always @(posedge clk) begin
		if (!arst_n || (start && !busy) || done) begin
			quiet_cycles <= 0;
		end else if (quiet_cycles >= QUIET_LIMIT) begin
			$display("*** FAILED ***");
			$finish;
		end else begin
			quiet_cycles <= quiet_cycles + 1;
		end
	end

	function automatic logic [KEY_W-1:0] any_key();
		return {$urandom, $urandom};
	endfunction

	function automatic void keep_hot(input logic [ADDR_W-1:0] a);
		hot_addrs.insert(hot_addrs.size(), a);
		if (hot_addrs.size() > 24)
			void'(hot_addrs.pop_front());
	endfunction

	// returns at the edge that takes the transaction; start is left high
	task automatic send(input logic rt, input logic [KEY_W-1:0] k,
			input logic [ADDR_W-1:0] a, input logic [LEN_W-1:0] len);
		while ($urandom_range(0, 99) < idle_pct) begin
			start <= 1'b0;
			@(posedge clk);
		end
		start <= 1'b1;
		req_type <= rt;
		key <= k;
		address <= a;
		length <= len;
		@(posedge clk);
		while (busy)
			@(posedge clk);
	endtask

	task automatic protect(input logic [KEY_W-1:0] k, input logic [ADDR_W-1:0] a,
			input logic [LEN_W-1:0] len);
		send(REQ_PROTECT, k, a, len);
		if (len != 0 && len <= 32'hFFFF_F000)
			keep_hot(a + $urandom_range(0, len - 1));
	endtask

	task automatic notice(input logic [ADDR_W-1:0] a);
		send(REQ_NOTICE, any_key(), a, $urandom);
	endtask

	task automatic random_item();
		int pick;
		int idx;
		logic [ADDR_W-1:0] a;
		logic [LEN_W-1:0] len;
		pick = $urandom_range(0, 99);
		if (pick < 45) begin
			if ($urandom_range(0, 99) < 80)
				a = 32'h0010_0000 + $urandom_range(0, 32'h0003_FFFF);
			else
				a = $urandom;
			pick = $urandom_range(0, 99);
			if (pick < 70)
				len = $urandom_range(1, 4 * PAGE_SIZE);
			else if (pick < 78)
				len = '0;
			else if (pick < 86)
				len = $urandom_range(32'hFFFF_E000, 32'hFFFF_FFFF);
			else
				len = $urandom;
			protect(any_key(), a, len);
		end else begin
			pick = $urandom_range(0, 99);
			if (pick < 60 && hot_addrs.size() > 0) begin
				idx = $urandom_range(0, hot_addrs.size() - 1);
				a = hot_addrs[idx];
				hot_addrs.delete(idx);
			end else if (pick < 80) begin
				a = 32'h0010_0000 + $urandom_range(0, 32'h0004_FFFF);
			end else if (pick < 85) begin
				a = ($urandom_range(0, 1) != 0) ? 32'hFFFF_FFFF : 32'h0000_0000;
			end else begin
				a = $urandom;
			end
			notice(a);
		end
	endtask

	initial begin
		arst_n <= 1'b0;
		start <= 1'b0;
		req_type <= REQ_PROTECT;
		key <= '0;
		address <= '0;
		length <= '0;
		repeat (3) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// empty table, zero length, overflowing lengths
		notice(32'h0000_0000);
		protect('0, 32'h0000_0000, 32'h0000_0000);
		protect('1, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
		protect(any_key(), 32'h1234_5678, 32'hFFFF_F001);
		// top page, near-whole space, range running past the top
		protect('1, 32'hFFFF_F123, 32'h0000_0001);
		protect('0, 32'h0000_0000, 32'hFFFF_F000);
		protect(any_key(), 32'hFFFF_E800, 32'h0000_1801);
		notice(32'hFFFF_F000);
		notice(32'hFFFF_EFFF);
		// fill every slot on one page, overfill, then release them all at once
		for (int i = 0; i < TABLE_DEPTH; i++)
			protect(any_key(), 32'h4000_0000 | $urandom_range(0, PAGE_SIZE - 1),
				$urandom_range(1, PAGE_SIZE));
		protect(any_key(), 32'h4000_0000, 32'h0000_0010);
		notice(32'h4000_0FFF);
		hot_addrs.delete();

		foreach (idle_plan[p]) begin
			idle_pct = idle_plan[p];
			for (int i = 0; i < PHASE_ITEMS; i++)
				random_item();
		end
		start <= 1'b0;

		@(posedge clk);
		while (pending != 0 || busy)
			@(posedge clk);
		repeat (TABLE_DEPTH + 4) @(posedge clk);
		if (failures == 0)
			$display("*** PASSED ***");
		else
			$display("*** FAILED ***");
		$finish;
	end

endmodule
